>>> design/olst_pkg.sv
// Shared types and codes for the ordered list store.
`default_nettype none

package olst_pkg;

  typedef enum logic [1:0] {
    OP_FRONT  = 2'd0,
    OP_BACK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FOUND     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic front;    // shift one place toward the back, cell 0 takes the key
    logic back;     // the cell at the fill position takes the key
    logic compare;  // latch the match flag and own index
    logic scan;     // merge the first-match window from a left tap
    logic remove;   // cells at or after the first match take the right neighbour
  } olst_cell_ctl_t;

endpackage

`default_nettype wire

>>> design/ordered_list_store.sv
// Top level of the ordered list store: command sequencer and the chain of cells.
//
// A command is taken at a rising edge with start high and busy low. operation
// selects insert at the front, append at the back, delete the first match or
// search; value carries the 32-bit key. Every command returns one result beat:
// done is high for exactly one cycle with status, position and entry_count.
// The receiver cannot stall, so the beat is simply dropped onto the ports.
//
// Insert and append finish in the accept cycle: the result shows in the next
// cycle and busy never rises, so one of them may follow every cycle.
// Delete and search compare all entries at once in the accept cycle, then run
// a distance-doubling first-match scan along the chain, one level a cycle,
// then apply the shift and register the result. They hold busy through the
// scan and the apply step, so a new command waits until both are over; the
// scan depth sets how long busy stays high.
// Reset empties the store at once (fill count to zero); no clearing pass.
// Entries beyond the fill count never match a search or delete.
`default_nettype none

module ordered_list_store
  import olst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       position,
  output logic [6:0]       entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SCAN_STEPS = $clog2(CAPACITY);
  localparam int NT = (SCAN_STEPS > 0) ? SCAN_STEPS : 1;
  localparam int SW = (NT > 1) ? $clog2(NT) : 1;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    APPLY
  } state_t;

  state_t          state;
  op_t             op_in;
  op_t             op_q;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [SW-1:0]   step;
  logic            accept;
  logic            full;
  logic            hit;
  status_t         status_next;
  olst_cell_ctl_t  ctl;

  logic [31:0]     cell_value [CAPACITY];
  logic            cell_found [CAPACITY];
  logic [IW-1:0]   cell_idx   [CAPACITY];

  logic [CW+6:0]   count_wide;
  logic [IW+5:0]   pos_wide;

  assign op_in  = op_t'(operation);
  assign accept = start && (state == IDLE);
  assign busy   = (state != IDLE);
  assign full   = (count == CW'(CAPACITY));
  // The last cell's window covers the whole chain once the scan is over.
  assign hit    = cell_found[CAPACITY-1];

  always_comb begin
    ctl         = '0;
    ctl.front   = accept && (op_in == OP_FRONT) && !full;
    ctl.back    = accept && (op_in == OP_BACK) && !full;
    ctl.compare = accept && ((op_in == OP_DELETE) || (op_in == OP_SEARCH));
    ctl.scan    = (state == SCAN);
    ctl.remove  = (state == APPLY) && (op_q == OP_DELETE) && hit;
  end

  // Result of the command finishing this cycle and the fill count it leaves.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (state == APPLY) begin
      if (op_q == OP_DELETE) begin
        priority if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (hit) begin
          status_next = ST_OK;
          count_next  = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end else begin
        status_next = hit ? ST_FOUND : ST_NOT_FOUND;
      end
    end else if (full) begin
      status_next = ST_FULL;
    end else begin
      count_next = count + CW'(1);
    end
  end

  // Zero-extend then cut, so the ports wrap when the capacity outgrows them.
  assign count_wide = {7'd0, count_next};
  assign pos_wide   = {6'd0, cell_idx[CAPACITY-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      count <= '0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (ctl.compare) begin
              op_q  <= op_in;
              step  <= '0;
              state <= (SCAN_STEPS > 0) ? SCAN : APPLY;
            end else begin
              // Insert or append: report at once, hold the count when full.
              done        <= 1'b1;
              status      <= status_next;
              position    <= '0;
              entry_count <= count_wide[6:0];
              count       <= count_next;
            end
          end
        end
        SCAN: begin
          if (step == SW'(NT - 1)) begin
            state <= APPLY;
          end else begin
            step <= step + SW'(1);
          end
        end
        APPLY: begin
          done        <= 1'b1;
          status      <= status_next;
          position    <= ((op_q == OP_SEARCH) && hit) ? pos_wide[5:0] : 6'd0;
          entry_count <= count_wide[6:0];
          count       <= count_next;
          state       <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Chain of cells; tap k of cell i looks 2**k cells toward the front.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          tap_found [NT];
    logic [IW-1:0] tap_idx   [NT];
    logic [31:0]   left_value;
    logic [31:0]   right_value;

    for (genvar k = 0; k < NT; k++) begin : g_tap
      if ((SCAN_STEPS > 0) && (i >= (1 << k))) begin : g_link
        assign tap_found[k] = cell_found[i - (1 << k)];
        assign tap_idx[k]   = cell_idx[i - (1 << k)];
      end else begin : g_edge
        assign tap_found[k] = 1'b0;
        assign tap_idx[k]   = '0;
      end
    end

    if (i == 0) begin : g_head
      assign left_value = value;
    end else begin : g_body
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    olst_cell #(
      .INDEX (i),
      .CW    (CW),
      .IW    (IW),
      .NT    (NT),
      .SW    (SW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (value),
      .count       (count),
      .left_value  (left_value),
      .right_value (right_value),
      .tap_found   (tap_found),
      .tap_idx     (tap_idx),
      .step        (step),
      .value       (cell_value[i]),
      .found       (cell_found[i]),
      .idx         (cell_idx[i])
    );
  end

endmodule

`default_nettype wire

>>> design/olst_cell.sv
// One cell of the ordered list store chain: an entry and its first-match scan state.
`default_nettype none

module olst_cell
  import olst_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW    = 7,
  parameter int IW    = 6,
  parameter int NT    = 1,
  parameter int SW    = 1
) (
  input  wire logic           clk,
  input  wire olst_cell_ctl_t ctl,
  input  wire logic [31:0]    key,
  input  wire logic [CW-1:0]  count,
  input  wire logic [31:0]    left_value,
  input  wire logic [31:0]    right_value,
  input  wire logic           tap_found [NT],
  input  wire logic [IW-1:0]  tap_idx   [NT],
  input  wire logic [SW-1:0]  step,
  output logic      [31:0]    value,
  output logic                found,
  output logic      [IW-1:0]  idx
);

  logic in_use;

  assign in_use = CW'(INDEX) < count;

  always_ff @(posedge clk) begin
    priority if (ctl.front) begin
      value <= left_value;
    end else if (ctl.back && (CW'(INDEX) == count)) begin
      value <= key;
    end else if (ctl.remove && found) begin
      value <= right_value;
    end
  end

  // Scan state: flag and index of the first match inside this cell's window.
  always_ff @(posedge clk) begin
    priority if (ctl.compare) begin
      found <= in_use && (value == key);
      idx   <= IW'(INDEX);
    end else if (ctl.scan && tap_found[step]) begin
      found <= 1'b1;
      idx   <= tap_idx[step];
    end
  end

endmodule

`default_nettype wire
